// ===== hdl/id3tfe_pkg.sv =====
// ----------------------------------------------------------------------------
// id3tfe_pkg
// Types and constants shared by the ID3v2 tag field extractor modules.
// ----------------------------------------------------------------------------
package id3tfe_pkg;

  typedef enum logic [2:0] {
    KIND_CHAR      = 3'd0,
    KIND_STR_END   = 3'd1,
    KIND_GENRE     = 3'd2,
    KIND_GENRE_UNK = 3'd3,
    KIND_DONE      = 3'd4,
    KIND_TRUNC     = 3'd5,
    KIND_REJECT    = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    FLD_ARTIST = 2'd0,
    FLD_TITLE  = 2'd1,
    FLD_ALBUM  = 2'd2,
    FLD_GENRE  = 2'd3
  } field_e;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_LABEL  = 3'd1,
    PH_SIZE   = 3'd2,
    PH_FLAGS  = 3'd3,
    PH_BODY   = 3'd4,
    PH_IDLE   = 3'd5
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    field_e     field;
    logic [7:0] value;
    logic       last;
  } out_item_t;

  // results of one parse step, up to two
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  r0;
    out_item_t  r1;
  } step_res_t;

  localparam logic [7:0]  CH_I      = 8'h49;
  localparam logic [7:0]  CH_D      = 8'h44;
  localparam logic [7:0]  CH_3      = 8'h33;
  localparam logic [7:0]  CH_PAREN  = 8'h28;
  localparam logic [7:0]  CH_ZERO   = 8'h30;
  localparam logic [7:0]  CH_NINE   = 8'h39;
  localparam logic [7:0]  VER_MIN   = 8'd2;
  localparam logic [7:0]  VER_MAX   = 8'd4;
  localparam logic [28:0] HDR_LEN   = 29'd10;
  localparam logic [28:0] OFFSET_MAX = 29'h1FFF_FFFF;

  localparam logic [23:0] LBL_TP1  = 24'h545031;
  localparam logic [23:0] LBL_TT2  = 24'h545432;
  localparam logic [23:0] LBL_TAL  = 24'h54414C;
  localparam logic [23:0] LBL_TCO  = 24'h54434F;
  localparam logic [31:0] LBL_TOLY = 32'h544F4C59;
  localparam logic [31:0] LBL_TOPE = 32'h544F5045;
  localparam logic [31:0] LBL_TPE1 = 32'h54504531;
  localparam logic [31:0] LBL_TPE2 = 32'h54504532;
  localparam logic [31:0] LBL_TIT2 = 32'h54495432;
  localparam logic [31:0] LBL_TCON = 32'h54434F4E;

endpackage

// ===== hdl/id3tfe_parser.sv =====
// ----------------------------------------------------------------------------
// id3tfe_parser
// Parse state and one-byte step logic: header check, frame walk, text and
// genre extraction. Produces up to two results per stepped byte.
// ----------------------------------------------------------------------------
module id3tfe_parser import id3tfe_pkg::*; #(
  parameter int MAX_STRING  = 64,
  parameter int GENRE_COUNT = 126
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  in_item_t  item,
  output step_res_t res
);

  localparam int CW = $clog2(MAX_STRING);

  phase_e           phase_r, phase_nxt, ph;
  logic [3:0]       idx_r, idx_nxt, idx, idx1, hlen;
  logic [2:0]       major_r, major_nxt, major;
  logic [28:0]      tag_end_r, tag_end_nxt, tag_end, tag_acc;
  logic [28:0]      foff_r, foff_nxt, foff;
  logic [31:0]      label_r, label_nxt, label;
  logic [31:0]      flen_r, flen_nxt, flen, flen_shift;
  logic [31:0]      left_r, left_nxt, left, left_dec;
  logic             tgt_on_r, tgt_on_nxt, tgt_on;
  field_e           tgt_fld_r, tgt_fld_nxt, tgt_fld;
  logic [CW-1:0]    ccnt_r, ccnt_nxt, ccnt, cnt1;
  logic [7:0]       gacc_r, gacc_nxt, gacc, gval, gsat;
  logic             gopen_r, gopen_nxt, gopen;

  logic [7:0]       b;
  logic             wide, is_artist, is_title, is_album, is_genre;
  logic [23:0]      pre3;
  logic             bb_go;
  logic [31:0]      bb_len;
  logic             fin_b, first_pos, is_last;
  logic [11:0]      gmul;
  logic             e0_v, e1_v;
  out_item_t        e0, e1;

  assign b = item.data_byte;

  // first byte of a file restarts from the reset state
  always_comb begin
    if (item.first_byte) begin
      ph = PH_HEADER;  idx = '0;  major = '0;  tag_end = '0;  foff = '0;
      label = '0;  flen = '0;  left = '0;  tgt_on = 1'b0;  tgt_fld = FLD_ARTIST;
      ccnt = '0;  gacc = '0;  gopen = 1'b0;
    end else begin
      ph = phase_r;  idx = idx_r;  major = major_r;  tag_end = tag_end_r;
      foff = foff_r;  label = label_r;  flen = flen_r;  left = left_r;
      tgt_on = tgt_on_r;  tgt_fld = tgt_fld_r;  ccnt = ccnt_r;  gacc = gacc_r;
      gopen = gopen_r;
    end
  end

  // frame label matching
  assign wide = (major >= 3'd3);
  assign pre3 = wide ? label[31:8] : label[23:0];
  assign is_artist = (pre3 == LBL_TP1) ||
                     (wide && ((label == LBL_TOLY) || (label == LBL_TOPE) ||
                               (label == LBL_TPE1) || (label == LBL_TPE2)));
  assign is_title  = (pre3 == LBL_TT2) || (wide && (label == LBL_TIT2));
  assign is_album  = (pre3 == LBL_TAL);
  assign is_genre  = (pre3 == LBL_TCO) && (!wide || (label == LBL_TCON));

  assign hlen       = wide ? 4'd4 : 4'd3;
  assign idx1       = idx + 4'd1;
  assign tag_acc    = (idx >= 4'd6) ? {1'b0, tag_end[20:0], b[6:0]} : tag_end;
  assign flen_shift = (major >= 3'd4) ? {flen[24:0], b[6:0]} : {flen[23:0], b};
  assign fin_b      = (left == 32'd1);
  assign first_pos  = (left == flen);
  assign left_dec   = left - 32'd1;
  assign cnt1       = ccnt + CW'(1);
  assign is_last    = fin_b || (cnt1 >= CW'(MAX_STRING - 1));
  assign gmul       = {4'd0, gacc} * 12'd10 + {4'd0, b - CH_ZERO};
  assign gsat       = (gmul > 12'd255) ? 8'hFF : gmul[7:0];

  always_comb begin
    phase_nxt = ph;  idx_nxt = idx;  major_nxt = major;  tag_end_nxt = tag_end;
    label_nxt = label;  flen_nxt = flen;  left_nxt = left;  tgt_on_nxt = tgt_on;
    tgt_fld_nxt = tgt_fld;  ccnt_nxt = ccnt;  gacc_nxt = gacc;  gopen_nxt = gopen;
    e0_v = 1'b0;  e0 = '0;  e1_v = 1'b0;  e1 = '0;
    bb_go = 1'b0;  bb_len = flen;  gval = gacc;

    case (ph)
      PH_HEADER: begin
        if ((idx == 4'd0 && b != CH_I) || (idx == 4'd1 && b != CH_D) ||
            (idx == 4'd2 && b != CH_3) ||
            (idx == 4'd3 && (b < VER_MIN || b > VER_MAX))) begin
          e0_v = 1'b1;  e0.kind = KIND_REJECT;
          phase_nxt = PH_IDLE;
        end else begin
          if (idx == 4'd3) major_nxt = b[2:0];
          tag_end_nxt = tag_acc;
          if (idx >= 4'd9) begin
            if (tag_acc == '0) begin
              e0_v = 1'b1;  e0.kind = KIND_REJECT;
              phase_nxt = PH_IDLE;
            end else begin
              tag_end_nxt = tag_acc + HDR_LEN;
              phase_nxt = PH_LABEL;
              idx_nxt = '0;
            end
          end else begin
            idx_nxt = idx1;
          end
        end
      end
      PH_LABEL: begin
        if (idx == 4'd0 && (foff >= tag_end || b == 8'd0)) begin
          // padding or tag end where a frame would start
          e0_v = 1'b1;  e0.kind = KIND_DONE;  e0.value = {5'd0, major};
          phase_nxt = PH_IDLE;
        end else begin
          label_nxt = (idx == 4'd0) ? {24'd0, b} : {label[23:0], b};
          idx_nxt = idx1;
          if (idx1 >= hlen) begin
            phase_nxt = PH_SIZE;
            idx_nxt = '0;
            flen_nxt = '0;
          end
        end
      end
      PH_SIZE: begin
        flen_nxt = flen_shift;
        idx_nxt = idx1;
        if (idx1 >= hlen) begin
          idx_nxt = '0;
          if (wide) phase_nxt = PH_FLAGS;
          else begin
            bb_go = 1'b1;
            bb_len = flen_shift;
          end
        end
      end
      PH_FLAGS: begin
        idx_nxt = idx1;
        if (idx1 >= 4'd2) bb_go = 1'b1;
      end
      PH_BODY: begin
        if (tgt_on) begin
          if (first_pos) begin
            // encoding byte: only latin-1 is taken
            if (b != 8'd0) tgt_on_nxt = 1'b0;
            else if (fin_b && tgt_fld != FLD_GENRE) begin
              e0_v = 1'b1;  e0.kind = KIND_STR_END;  e0.field = tgt_fld;
            end
          end else if (tgt_fld != FLD_GENRE) begin
            if (b == 8'd0) begin
              e0_v = 1'b1;  e0.kind = KIND_STR_END;  e0.field = tgt_fld;
              tgt_on_nxt = 1'b0;
            end else begin
              ccnt_nxt = cnt1;
              e0_v = 1'b1;  e0.kind = KIND_CHAR;  e0.field = tgt_fld;
              e0.value = b;  e0.last = is_last;
              if (is_last) tgt_on_nxt = 1'b0;
            end
          end else if (!gopen) begin
            if (b != CH_PAREN) tgt_on_nxt = 1'b0;
            else begin
              gopen_nxt = 1'b1;
              if (fin_b) e0_v = 1'b1;
            end
          end else begin
            if (b >= CH_ZERO && b <= CH_NINE) begin
              gacc_nxt = gsat;
              gval = gsat;
              if (fin_b) e0_v = 1'b1;
            end else begin
              e0_v = 1'b1;
            end
          end
          if (e0_v && tgt_fld == FLD_GENRE) begin
            e0.kind = ({1'b0, gval} < 9'(GENRE_COUNT)) ? KIND_GENRE : KIND_GENRE_UNK;
            e0.field = FLD_GENRE;
            e0.value = gval;
            tgt_on_nxt = 1'b0;
          end
        end
        left_nxt = left_dec;
        if (left_dec == '0) begin
          phase_nxt = PH_LABEL;
          idx_nxt = '0;
          tgt_on_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase

    if (bb_go) begin
      tgt_on_nxt = (is_artist || is_title || is_album || is_genre) && (bb_len != '0);
      tgt_fld_nxt = is_artist ? FLD_ARTIST : is_title ? FLD_TITLE :
                    is_album ? FLD_ALBUM : FLD_GENRE;
      ccnt_nxt = '0;
      gacc_nxt = '0;
      gopen_nxt = 1'b0;
      left_nxt = bb_len;
      idx_nxt = '0;
      phase_nxt = (bb_len != '0) ? PH_BODY : PH_LABEL;
    end

    foff_nxt = (foff == OFFSET_MAX) ? foff : foff + 29'd1;

    if (item.final_byte && phase_nxt != PH_IDLE) begin
      e1_v = 1'b1;
      e1.kind = (phase_nxt == PH_LABEL && idx_nxt == '0 && foff_nxt >= tag_end_nxt) ?
                KIND_DONE : KIND_TRUNC;
      e1.value = {5'd0, major_nxt};
      phase_nxt = PH_IDLE;
    end
  end

  always_comb begin
    res.cnt = {1'b0, e0_v} + {1'b0, e1_v};
    res.r0  = e0_v ? e0 : e1;
    res.r1  = e1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      idx_r     <= '0;
      major_r   <= '0;
      tag_end_r <= '0;
      foff_r    <= '0;
      label_r   <= '0;
      flen_r    <= '0;
      left_r    <= '0;
      tgt_on_r  <= 1'b0;
      tgt_fld_r <= FLD_ARTIST;
      ccnt_r    <= '0;
      gacc_r    <= '0;
      gopen_r   <= 1'b0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      idx_r     <= idx_nxt;
      major_r   <= major_nxt;
      tag_end_r <= tag_end_nxt;
      foff_r    <= foff_nxt;
      label_r   <= label_nxt;
      flen_r    <= flen_nxt;
      left_r    <= left_nxt;
      tgt_on_r  <= tgt_on_nxt;
      tgt_fld_r <= tgt_fld_nxt;
      ccnt_r    <= ccnt_nxt;
      gacc_r    <= gacc_nxt;
      gopen_r   <= gopen_nxt;
    end
  end

endmodule

// ===== hdl/id3v2_tag_field_extractor.sv =====
// results pass from the input register through the parse step into the result queue
// throughput: one byte per cycle while each byte yields at most one result
//   and out_stall is low; two results of one byte both queue for the single-beat port
// the four-entry result queue sets how far the input runs ahead of the output
// reset (rst_n low, synchronous) clears the parse state and the result queue;
//   first_byte restarts parsing without a reset
// ----------------------------------------------------------------------------
// id3v2_tag_field_extractor
// Byte-stream ID3v2 parser: input register, parse step, result queue.
// ----------------------------------------------------------------------------
module id3v2_tag_field_extractor import id3tfe_pkg::*; #(
  parameter int MAX_STRING  = 64,
  parameter int GENRE_COUNT = 126
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      room, step_en, in_acc, pop;
  step_res_t res;
  logic [1:0] push_n;

  out_item_t  q_r [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] count_r, count_nxt;

  // two free slots needed before a byte is stepped
  assign room     = (count_r <= 3'd2);
  assign step_en  = s1_valid_r && room;
  assign in_stall = s1_valid_r && !room;
  assign in_acc   = in_valid && !in_stall;
  assign s1_valid_nxt = in_acc || (s1_valid_r && !room);

  id3tfe_parser #(
    .MAX_STRING  (MAX_STRING),
    .GENRE_COUNT (GENRE_COUNT)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (s1_item_r),
    .res     (res)
  );

  assign push_n    = step_en ? res.cnt : 2'd0;
  assign out_valid = (count_r != 3'd0);
  assign out_data  = q_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign count_nxt = count_r + {1'b0, push_n} - {2'd0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      count_r    <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      wr_ptr_r   <= wr_ptr_r + push_n;
      rd_ptr_r   <= rd_ptr_r + {1'b0, pop};
      count_r    <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_item_r <= in_data;
    if (push_n != 2'd0) q_r[wr_ptr_r] <= res.r0;
    if (push_n == 2'd2) q_r[wr_ptr_r + 2'd1] <= res.r1;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'd4)
    else $error("result queue overflow");

  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !room) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("held byte lost");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && push_n == 2'd0) |=> (count_r == $past(count_r) - 3'd1))
    else $error("queue count mismatch");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != 3'd4) |-> ((wr_ptr_r - rd_ptr_r) == count_r[1:0]))
    else $error("queue pointers out of step");
`endif

endmodule
